[hw/rtl/ipcmq_pkg.sv]
// ----------------------------------------------------------------------------
// ipcmq_pkg: shared types and codes for the message mailbox
// Opcodes, status codes, configuration register indexes and the request and
// result structs passed between the mailbox modules.
// ----------------------------------------------------------------------------
package ipcmq_pkg;

    typedef logic [2:0] t_opcode;
    typedef logic [2:0] t_status;
    typedef logic       t_cfg_index;

    localparam t_opcode OP_SEND       = 3'd0;
    localparam t_opcode OP_RECEIVE    = 3'd1;
    localparam t_opcode OP_SIGNAL     = 3'd2;
    localparam t_opcode OP_SHUT_CONS  = 3'd3;
    localparam t_opcode OP_SHUT_PROD  = 3'd4;

    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_UNREACHABLE = 3'd1;
    localparam t_status ST_QUOTA       = 3'd2;
    localparam t_status ST_EMPTY       = 3'd3;
    localparam t_status ST_INVALID     = 3'd4;

    localparam t_cfg_index CFG_QUEUE_QUOTA = 1'b0;
    localparam t_cfg_index CFG_NOTIFY_TAG  = 1'b1;

    localparam logic [4:0] QUOTA_RESET = 5'd16;

    typedef struct packed {
        t_opcode     opcode;
        logic [7:0]  msg_length;
        logic [63:0] msg_payload;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [3:0]  out_length;
        logic [63:0] out_payload;
        logic        notify_valid;
        logic [31:0] notify_value;
    } t_result;

endpackage

[hw/rtl/ipc_message_queue_with_notify.sv]
// ----------------------------------------------------------------------------
// ipc_message_queue_with_notify: bounded message mailbox with notification
// Request register, single-pass evaluation against mailbox state and a result
// register, with a two-entry configuration register set.
// ----------------------------------------------------------------------------
// The mailbox returns one result for each request it takes. The request sits
// in the request register while a single evaluation pass updates the indexes,
// count and flags, and the result lands in the result register once the result
// side is free to take it. Throughput is one request per clock as long as the
// result side keeps up; it is set by the single evaluation pass and by the slot
// memory's registered read, which is addressed ahead with the next read index
// and forwards a slot written in that same cycle. Configuration writes take
// effect on the next clock and are meant to be made while the block is idle.
module ipc_message_queue_with_notify #(
    parameter int DEPTH         = 16,
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_msg_length,
    input  logic [63:0] i_msg_payload,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [3:0]  o_out_length,
    output logic [63:0] o_out_payload,
    output logic        o_notify_valid,
    output logic [31:0] o_notify_value
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                r_in_valid;
    ipcmq_pkg::t_request r_req;
    logic                r_out_valid;
    ipcmq_pkg::t_result  r_out;
    logic [4:0]          r_quota;
    logic [31:0]         r_tag;

    logic                step;
    logic                in_take;
    ipcmq_pkg::t_result  result;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [3:0]          wr_length;
    logic [63:0]         wr_payload;
    logic [AW-1:0]       rd_addr;
    logic [3:0]          rd_length;
    logic [63:0]         rd_payload;

    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quota <= ipcmq_pkg::QUOTA_RESET;
            r_tag   <= 32'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ipcmq_pkg::CFG_QUEUE_QUOTA: r_quota <= i_cfg_data[4:0];
                ipcmq_pkg::CFG_NOTIFY_TAG:  r_tag   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req.opcode      <= i_opcode;
            r_req.msg_length  <= i_msg_length;
            r_req.msg_payload <= i_msg_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    ipcmq_core #(
        .DEPTH         (DEPTH),
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .AW            (AW)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_req        (r_req),
        .i_quota      (r_quota),
        .i_tag        (r_tag),
        .i_rd_length  (rd_length),
        .i_rd_payload (rd_payload),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_length  (wr_length),
        .o_wr_payload (wr_payload),
        .o_rd_addr    (rd_addr),
        .o_result     (result)
    );

    ipcmq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_length  (wr_length),
        .i_wr_payload (wr_payload),
        .i_rd_addr    (rd_addr),
        .o_rd_length  (rd_length),
        .o_rd_payload (rd_payload)
    );

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_out_length   = r_out.out_length;
    assign o_out_payload  = r_out.out_payload;
    assign o_notify_valid = r_out.notify_valid;
    assign o_notify_value = r_out.notify_value;

endmodule

[hw/rtl/ipcmq_store.sv]
// ----------------------------------------------------------------------------
// ipcmq_store: message slot memory
// One write port and one registered read port, with forwarding of a write
// that lands on the address being read in the same cycle.
// ----------------------------------------------------------------------------
module ipcmq_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [3:0]    i_wr_length,
    input  logic [63:0]   i_wr_payload,
    input  logic [AW-1:0] i_rd_addr,
    output logic [3:0]    o_rd_length,
    output logic [63:0]   o_rd_payload
);

    logic [63:0] r_mem_payload [DEPTH];
    logic [3:0]  r_mem_length  [DEPTH];
    logic [63:0] r_rd_payload;
    logic [3:0]  r_rd_length;
    logic        r_fwd_hit;
    logic [63:0] r_fwd_payload;
    logic [3:0]  r_fwd_length;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_payload[i_wr_addr] <= i_wr_payload;
            r_mem_length[i_wr_addr]  <= i_wr_length;
        end
        r_rd_payload  <= r_mem_payload[i_rd_addr];
        r_rd_length   <= r_mem_length[i_rd_addr];
        r_fwd_payload <= i_wr_payload;
        r_fwd_length  <= i_wr_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    // memory read returns old data on a same-address write: take the new data
    assign o_rd_payload = r_fwd_hit ? r_fwd_payload : r_rd_payload;
    assign o_rd_length  = r_fwd_hit ? r_fwd_length  : r_rd_length;

endmodule

[hw/rtl/ipcmq_core.sv]
// ----------------------------------------------------------------------------
// ipcmq_core: mailbox state and single-pass request evaluation
// Holds the ring indexes, pending count and flags, evaluates one request
// against them and drives the slot memory write and read addresses.
// ----------------------------------------------------------------------------
module ipcmq_core #(
    parameter int DEPTH         = 16,
    parameter int PAYLOAD_BYTES = 8,
    parameter int AW            = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  ipcmq_pkg::t_request i_req,
    input  logic [4:0]          i_quota,
    input  logic [31:0]         i_tag,
    input  logic [3:0]          i_rd_length,
    input  logic [63:0]         i_rd_payload,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output logic [3:0]          o_wr_length,
    output logic [63:0]         o_wr_payload,
    output logic [AW-1:0]       o_rd_addr,
    output ipcmq_pkg::t_result  o_result
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;

    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_count, n_count;
    logic          r_closed, n_closed;
    logic          r_raised, n_raised;

    logic [CMPW-1:0] quota_ext;
    logic [CMPW-1:0] quota_eff;
    logic [CMPW-1:0] count_ext;
    logic            len_bad;
    logic            send_ok;

    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        for (int b = 0; b < 8; b++) begin
            m[8*b +: 8] = (len > 4'(b)) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
    endfunction

    assign quota_ext = CMPW'(i_quota);
    assign quota_eff = (quota_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : quota_ext;
    assign count_ext = CMPW'(r_count);
    assign len_bad   = i_req.msg_length > 8'(PAYLOAD_BYTES);

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_count  = r_count;
        n_closed = r_closed;
        n_raised = r_raised;
        send_ok  = 1'b0;
        o_result = '0;
        case (i_req.opcode)
            ipcmq_pkg::OP_SEND: begin
                if (len_bad) begin
                    o_result.status = ipcmq_pkg::ST_INVALID;
                end else if (r_closed) begin
                    o_result.status = ipcmq_pkg::ST_UNREACHABLE;
                end else if (count_ext >= quota_eff) begin
                    o_result.status = ipcmq_pkg::ST_QUOTA;
                end else begin
                    send_ok               = 1'b1;
                    n_wr_idx              = next_idx(r_wr_idx);
                    n_count               = r_count + CW'(1);
                    o_result.notify_valid = !r_raised;
                    n_raised              = 1'b1;
                end
            end
            ipcmq_pkg::OP_RECEIVE: begin
                if (r_closed) begin
                    o_result.status = ipcmq_pkg::ST_UNREACHABLE;
                end else if (r_count == '0) begin
                    o_result.status = ipcmq_pkg::ST_EMPTY;
                end else begin
                    o_result.out_length  = i_rd_length;
                    o_result.out_payload = i_rd_payload & byte_mask(i_rd_length);
                    n_rd_idx             = next_idx(r_rd_idx);
                    n_count              = r_count - CW'(1);
                    n_raised             = 1'b0;
                end
            end
            ipcmq_pkg::OP_SIGNAL: begin
                if (r_closed) begin
                    o_result.status = ipcmq_pkg::ST_UNREACHABLE;
                end else begin
                    o_result.notify_valid = !r_raised;
                    n_raised              = 1'b1;
                end
            end
            ipcmq_pkg::OP_SHUT_CONS: begin
                n_closed = 1'b1;
            end
            ipcmq_pkg::OP_SHUT_PROD: begin
                if (!r_closed) begin
                    o_result.notify_valid = !r_raised;
                    n_raised              = 1'b1;
                end
                n_closed = 1'b1;
            end
            default: begin
                // unused opcodes: drop with success and no state change
            end
        endcase
        o_result.notify_value = o_result.notify_valid ? i_tag : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
            r_closed <= 1'b0;
            r_raised <= 1'b0;
        end else if (i_step) begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
            r_closed <= n_closed;
            r_raised <= n_raised;
        end
    end

    assign o_wr_en      = i_step && send_ok;
    assign o_wr_addr    = r_wr_idx;
    assign o_wr_length  = i_req.msg_length[3:0];
    assign o_wr_payload = i_req.msg_payload & byte_mask(i_req.msg_length[3:0]);
    // look ahead so the registered slot read is ready for the next request
    assign o_rd_addr    = i_step ? n_rd_idx : r_rd_idx;

endmodule

[hw/rtl/ipcmq_checker.sv]
// ----------------------------------------------------------------------------
// ipcmq_checker: port-level checks for the message mailbox
// Watches the result channel for held results and for consistency between
// status, received message and notification.
// ----------------------------------------------------------------------------
module ipcmq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_status,
    input logic [3:0]  o_out_length,
    input logic [63:0] o_out_payload,
    input logic        o_notify_valid,
    input logic [31:0] o_notify_value
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_out_length)
            && $stable(o_out_payload) && $stable(o_notify_valid))
        else $error("result changed while stalled");

    a_tag_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_notify_valid |-> o_notify_value == 32'd0)
        else $error("notification value without notification");

    a_refused_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ipcmq_pkg::ST_OK |->
            o_out_length == 4'd0 && o_out_payload == 64'd0 && !o_notify_valid)
        else $error("refused request carries data or notification");

    a_notify_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_notify_valid |->
            o_status == ipcmq_pkg::ST_OK && o_out_length == 4'd0
            && o_out_payload == 64'd0)
        else $error("notification together with a received message");

endmodule

bind ipc_message_queue_with_notify ipcmq_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_out_length   (o_out_length),
    .o_out_payload  (o_out_payload),
    .o_notify_valid (o_notify_valid),
    .o_notify_value (o_notify_value)
);

[tb/sv/ipc_message_queue_with_notify_tb.sv]
// ----------------------------------------------------------------------------
// ipc_message_queue_with_notify_tb: self-checking bench for the message mailbox
// Drives send, receive, signal, shutdown and reserved opcodes through the
// request channel, predicts every result with a behavioral mailbox model and
// checks status, returned message and notification field by field. Covers
// quota limits, wrap-around, stalls on both channels and the closed stream.
// ----------------------------------------------------------------------------
module ipc_message_queue_with_notify_tb;

    localparam int MBOX_DEPTH     = 16;
    localparam int MBOX_BYTES     = 8;
    localparam int DRAIN_SLACK    = 6;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_ITEMS    = 104;
    localparam int MAX_PRINTS     = 40;

    // Reserved opcodes: the block must answer them without touching state.
    localparam ipcmq_pkg::t_opcode OP_RSVD_5 = 3'd5;
    localparam ipcmq_pkg::t_opcode OP_RSVD_6 = 3'd6;
    localparam ipcmq_pkg::t_opcode OP_RSVD_7 = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_opcode;
    logic [7:0]  i_msg_length;
    logic [63:0] i_msg_payload;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_status;
    logic [3:0]  o_out_length;
    logic [63:0] o_out_payload;
    logic        o_notify_valid;
    logic [31:0] o_notify_value;

    ipc_message_queue_with_notify #(
        .DEPTH         (MBOX_DEPTH),
        .PAYLOAD_BYTES (MBOX_BYTES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_msg_length   (i_msg_length),
        .i_msg_payload  (i_msg_payload),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_out_length   (o_out_length),
        .o_out_payload  (o_out_payload),
        .o_notify_valid (o_notify_valid),
        .o_notify_value (o_notify_value)
    );

    // Mailbox model state
    logic [63:0] mb_slot_pay [MBOX_DEPTH];
    logic [3:0]  mb_slot_len [MBOX_DEPTH];
    int          mb_wr_ptr = 0;
    int          mb_rd_ptr = 0;
    int          mb_count  = 0;
    logic        mb_closed = 1'b0;
    logic        mb_raised = 1'b0;
    logic [4:0]  cfg_quota = ipcmq_pkg::QUOTA_RESET;
    logic [31:0] cfg_tag   = 32'd0;

    ipcmq_pkg::t_result mbox_expect_q [$];

    int mismatches      = 0;
    int n_requests      = 0;
    int n_results       = 0;
    int n_notes         = 0;
    int n_quota_refused = 0;
    int n_unreachable   = 0;
    int stall_cycles    = 0;
    int src_idle_pct    = 38;
    int sink_idle_pct   = 38;
    int sink_hold_req   = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [63:0] byte_keep(logic [7:0] len);
        if (len >= MBOX_BYTES) begin
            return '1;
        end
        return (64'd1 << (8 * len)) - 64'd1;
    endfunction

    function automatic logic raise_event();
        if (mb_raised) begin
            return 1'b0;
        end
        mb_raised = 1'b1;
        return 1'b1;
    endfunction

    function automatic ipcmq_pkg::t_result mbox_predict(ipcmq_pkg::t_request req);
        ipcmq_pkg::t_result res;
        int                 eff_quota;
        res        = '0;
        res.status = ipcmq_pkg::ST_OK;
        eff_quota  = (cfg_quota > MBOX_DEPTH) ? MBOX_DEPTH : int'(cfg_quota);
        case (req.opcode)
            ipcmq_pkg::OP_SEND: begin
                if (req.msg_length > MBOX_BYTES) begin
                    res.status = ipcmq_pkg::ST_INVALID;
                end else if (mb_closed) begin
                    res.status = ipcmq_pkg::ST_UNREACHABLE;
                end else if (mb_count >= eff_quota) begin
                    res.status = ipcmq_pkg::ST_QUOTA;
                end else begin
                    mb_slot_pay[mb_wr_ptr] = req.msg_payload & byte_keep(req.msg_length);
                    mb_slot_len[mb_wr_ptr] = req.msg_length[3:0];
                    mb_wr_ptr = (mb_wr_ptr + 1) % MBOX_DEPTH;
                    mb_count++;
                    res.notify_valid = raise_event();
                end
            end
            ipcmq_pkg::OP_RECEIVE: begin
                if (mb_closed) begin
                    res.status = ipcmq_pkg::ST_UNREACHABLE;
                end else if (mb_count == 0) begin
                    res.status = ipcmq_pkg::ST_EMPTY;
                end else begin
                    res.out_length  = mb_slot_len[mb_rd_ptr];
                    res.out_payload = mb_slot_pay[mb_rd_ptr]
                                      & byte_keep({4'd0, mb_slot_len[mb_rd_ptr]});
                    mb_rd_ptr = (mb_rd_ptr + 1) % MBOX_DEPTH;
                    mb_count--;
                    mb_raised = 1'b0;
                end
            end
            ipcmq_pkg::OP_SIGNAL: begin
                if (mb_closed) begin
                    res.status = ipcmq_pkg::ST_UNREACHABLE;
                end else begin
                    res.notify_valid = raise_event();
                end
            end
            ipcmq_pkg::OP_SHUT_CONS: begin
                mb_closed = 1'b1;
            end
            ipcmq_pkg::OP_SHUT_PROD: begin
                if (!mb_closed) begin
                    res.notify_valid = raise_event();
                end
                mb_closed = 1'b1;
            end
            default: begin
            end
        endcase
        if (res.notify_valid) begin
            res.notify_value = cfg_tag;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic send_req(ipcmq_pkg::t_opcode op, logic [7:0] len, logic [63:0] pay);
        ipcmq_pkg::t_request req;
        req = '{opcode: op, msg_length: len, msg_payload: pay};
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_msg_length  <= len;
        i_msg_payload <= pay;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        n_requests++;
        mbox_expect_q.push_back(mbox_predict(req));
    endtask

    function automatic logic [63:0] rand_payload();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [7:0] rand_length();
        if ($urandom_range(99) < 88) begin
            return 8'($urandom_range(MBOX_BYTES));
        end
        return 8'($urandom_range(255, MBOX_BYTES + 1));
    endfunction

    task automatic rand_item(int send_pct, int recv_pct);
        int pick;
        pick = $urandom_range(99);
        if (pick < send_pct) begin
            send_req(ipcmq_pkg::OP_SEND, rand_length(), rand_payload());
        end else if (pick < send_pct + recv_pct) begin
            send_req(ipcmq_pkg::OP_RECEIVE, rand_length(), rand_payload());
        end else if (pick < 97) begin
            send_req(ipcmq_pkg::OP_SIGNAL, rand_length(), rand_payload());
        end else begin
            send_req(ipcmq_pkg::t_opcode'($urandom_range(7, 5)), rand_length(),
                     rand_payload());
        end
    endtask

    // Drop valid and hold until every expected result is back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (mbox_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic cfg_write(ipcmq_pkg::t_cfg_index idx, logic [31:0] val);
        @(negedge i_clk);
        i_in_valid  <= 1'b0;
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == ipcmq_pkg::CFG_QUEUE_QUOTA) begin
            cfg_quota = val[4:0];
        end else begin
            cfg_tag = val;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    initial begin : sink_ctl
        int hold_left;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req > 0) begin
                hold_left     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatches < MAX_PRINTS) begin
            $display("MISMATCH result %0d: %s got %0h want %0h", n_results, what, got, want);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin : result_check
        ipcmq_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (mbox_expect_q.size() == 0) begin
                report_mismatch("result with nothing pending", 64'(o_status), 64'd0);
            end else begin
                want = mbox_expect_q.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_out_length !== want.out_length)
                    report_mismatch("out_length", 64'(o_out_length), 64'(want.out_length));
                if (o_out_payload !== want.out_payload)
                    report_mismatch("out_payload", o_out_payload, want.out_payload);
                if (o_notify_valid !== want.notify_valid)
                    report_mismatch("notify_valid", 64'(o_notify_valid),
                                    64'(want.notify_valid));
                if (o_notify_value !== want.notify_value)
                    report_mismatch("notify_value", 64'(o_notify_value),
                                    64'(want.notify_value));
                if (want.notify_valid) n_notes++;
                if (want.status == ipcmq_pkg::ST_QUOTA) n_quota_refused++;
                if (want.status == ipcmq_pkg::ST_UNREACHABLE) n_unreachable++;
            end
            n_results++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || i_cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", stall_cycles);
            $display("FAILED: results differ");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_basic_ops();
        send_req(ipcmq_pkg::OP_RECEIVE, 8'd0, '0);
        send_req(ipcmq_pkg::OP_SIGNAL, 8'd0, '0);
        send_req(ipcmq_pkg::OP_SIGNAL, 8'd255, '1);
        wait_drained();
        cfg_write(ipcmq_pkg::CFG_NOTIFY_TAG, 32'hFFFF_FFFF);
        send_req(ipcmq_pkg::OP_SEND, 8'd8, '1);
        send_req(ipcmq_pkg::OP_SEND, 8'd0, {$urandom, $urandom});
        send_req(ipcmq_pkg::OP_SEND, 8'd1, {$urandom, $urandom});
        send_req(ipcmq_pkg::OP_SEND, 8'd9, '1);
        send_req(ipcmq_pkg::OP_SEND, 8'd255, {$urandom, $urandom});
        // receive clears the raised flag, so the next send notifies again
        send_req(ipcmq_pkg::OP_RECEIVE, 8'd0, '0);
        send_req(ipcmq_pkg::OP_SEND, 8'd7, {$urandom, $urandom});
        repeat (4) send_req(ipcmq_pkg::OP_RECEIVE, 8'd0, '0);
        send_req(OP_RSVD_5, rand_length(), rand_payload());
        send_req(OP_RSVD_6, rand_length(), rand_payload());
        send_req(OP_RSVD_7, 8'd255, '1);
        wait_drained();
    endtask

    task automatic test_quota_limits();
        cfg_write(ipcmq_pkg::CFG_QUEUE_QUOTA, 32'd0);
        send_req(ipcmq_pkg::OP_SEND, 8'd4, {$urandom, $urandom});
        wait_drained();
        cfg_write(ipcmq_pkg::CFG_QUEUE_QUOTA, 32'd2);
        repeat (3) send_req(ipcmq_pkg::OP_SEND, 8'd8, {$urandom, $urandom});
        wait_drained();
        // lower the quota below the held count: sends refused until it drops
        cfg_write(ipcmq_pkg::CFG_QUEUE_QUOTA, 32'd1);
        send_req(ipcmq_pkg::OP_SEND, 8'd2, {$urandom, $urandom});
        send_req(ipcmq_pkg::OP_RECEIVE, 8'd0, '0);
        send_req(ipcmq_pkg::OP_SEND, 8'd3, {$urandom, $urandom});
        send_req(ipcmq_pkg::OP_RECEIVE, 8'd0, '0);
        send_req(ipcmq_pkg::OP_SEND, 8'd5, {$urandom, $urandom});
        send_req(ipcmq_pkg::OP_RECEIVE, 8'd0, '0);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int send_pct;
        int recv_pct;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            src_idle_pct  = 38;
            sink_idle_pct = 38;
            case (phase)
                0: begin
                    cfg_write(ipcmq_pkg::CFG_QUEUE_QUOTA, 32'(ipcmq_pkg::QUOTA_RESET));
                    cfg_write(ipcmq_pkg::CFG_NOTIFY_TAG, $urandom);
                    send_pct = 55;
                    recv_pct = 35;
                end
                1: begin
                    // full rate on both sides, send-heavy to hit the quota
                    cfg_write(ipcmq_pkg::CFG_QUEUE_QUOTA, 32'd31);
                    cfg_write(ipcmq_pkg::CFG_NOTIFY_TAG, 32'd0);
                    send_pct      = 70;
                    recv_pct      = 20;
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
                2: begin
                    cfg_write(ipcmq_pkg::CFG_QUEUE_QUOTA, 32'd0);
                    cfg_write(ipcmq_pkg::CFG_NOTIFY_TAG, $urandom);
                    send_pct = 30;
                    recv_pct = 60;
                end
                3: begin
                    cfg_write(ipcmq_pkg::CFG_QUEUE_QUOTA,
                              32'($urandom_range(1, MBOX_DEPTH - 1)));
                    cfg_write(ipcmq_pkg::CFG_NOTIFY_TAG, 32'hFFFF_FFFF);
                    send_pct = 50;
                    recv_pct = 40;
                end
                default: begin
                    cfg_write(ipcmq_pkg::CFG_QUEUE_QUOTA, 32'd17);
                    cfg_write(ipcmq_pkg::CFG_NOTIFY_TAG, $urandom);
                    send_pct = 40;
                    recv_pct = 50;
                end
            endcase
            repeat (PHASE_ITEMS) rand_item(send_pct, recv_pct);
            wait_drained();
        end
        src_idle_pct  = 38;
        sink_idle_pct = 38;
    endtask

    task automatic test_backpressure();
        cfg_write(ipcmq_pkg::CFG_QUEUE_QUOTA, 32'(ipcmq_pkg::QUOTA_RESET));
        // long hold on the result side; the block must fill and stall requests
        sink_hold_req = 150;
        repeat (40) rand_item(50, 40);
        wait_drained();
    endtask

    task automatic test_sender_pause();
        for (int round = 0; round < 3; round++) begin
            repeat (8) rand_item(50, 40);
            wait_drained();
        end
    endtask

    task automatic test_shutdown();
        cfg_write(ipcmq_pkg::CFG_NOTIFY_TAG, $urandom);
        send_req(ipcmq_pkg::OP_SEND, 8'd3, {$urandom, $urandom});
        send_req(ipcmq_pkg::OP_SEND, 8'd8, {$urandom, $urandom});
        send_req(ipcmq_pkg::OP_RECEIVE, 8'd0, '0);
        // stream open and flag clear: producer shutdown notifies once
        send_req(ipcmq_pkg::OP_SHUT_PROD, 8'd0, '0);
        send_req(ipcmq_pkg::OP_SEND, 8'd4, {$urandom, $urandom});
        send_req(ipcmq_pkg::OP_SEND, 8'd12, {$urandom, $urandom});
        send_req(ipcmq_pkg::OP_RECEIVE, 8'd0, '0);
        send_req(ipcmq_pkg::OP_SIGNAL, 8'd0, '0);
        send_req(ipcmq_pkg::OP_SHUT_CONS, 8'd0, '0);
        send_req(ipcmq_pkg::OP_SHUT_PROD, 8'd255, '1);
        send_req(OP_RSVD_7, 8'd0, '0);
        for (int k = 0; k < 30; k++) begin
            if (k % 10 == 5) begin
                send_req(($urandom_range(1) != 0) ? ipcmq_pkg::OP_SHUT_PROD
                                                  : ipcmq_pkg::OP_SHUT_CONS,
                         rand_length(), rand_payload());
            end else begin
                rand_item(40, 40);
            end
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = ipcmq_pkg::CFG_QUEUE_QUOTA;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_opcode      = ipcmq_pkg::OP_SEND;
        i_msg_length  = '0;
        i_msg_payload = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_quota_limits();
        test_random_traffic();
        test_backpressure();
        test_sender_pause();
        test_shutdown();

        repeat (DRAIN_SLACK) @(posedge i_clk);
        if (mbox_expect_q.size() != 0) begin
            report_mismatch("results never returned", 64'(mbox_expect_q.size()), 64'd0);
        end
        $display("Run covered %0d requests and %0d checked results: %0d notifications,",
                 n_requests, n_results, n_notes);
        $display("%0d quota refusals, %0d closed-stream answers, output stall and pauses.",
                 n_quota_refused, n_unreachable);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[ipc_message_queue_with_notify.f]
hw/rtl/ipcmq_pkg.sv
hw/rtl/ipcmq_store.sv
hw/rtl/ipcmq_core.sv
hw/rtl/ipc_message_queue_with_notify.sv
hw/rtl/ipcmq_checker.sv
tb/sv/ipc_message_queue_with_notify_tb.sv
